// ----- rtl/aepd_pkg.sv -----
// Shared types and constants for the auto-exposure PD / latency test block.
// No dependencies.
`timescale 1ns / 1ps
package aepd_pkg;

   localparam int unsigned MEAN_W   = 15;
   localparam int unsigned EXP_W    = 32;
   localparam int unsigned GAIN_W   = 16;
   localparam int unsigned AVG_W    = 13;
   localparam int unsigned PHASE_W  = 3;
   localparam int unsigned CNT_W    = 6;   // frame count plus headroom for the increment
   localparam int unsigned FCNT_W   = 5;
   localparam int unsigned MCNT_W   = 16;
   localparam int unsigned NUM_W    = 30;  // n*avg + cnt*256
   localparam int unsigned DEN_W    = 17;
   localparam int unsigned DIV_STEPS = NUM_W;
   localparam int unsigned DCNT_W   = 5;
   localparam int unsigned PADDR_W  = 5;

   localparam int unsigned SETTLE_FRAMES_DEF  = 3;
   localparam int unsigned TIMEOUT_FRAMES_DEF = 20;

   localparam logic [EXP_W-1:0]  EXP_HIGH_RST   = 32'd10000;
   localparam logic [EXP_W-1:0]  EXP_INIT_RST   = 32'd10000;
   localparam logic [GAIN_W-1:0] P_GAIN_RST     = 16'd1;
   localparam logic [MEAN_W-1:0] TARGET_RST     = 15'd100;

   // test phases
   localparam logic [PHASE_W-1:0] PH_INIT      = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SETTLE_LO = 3'd1;
   localparam logic [PHASE_W-1:0] PH_SETTLE_HI = 3'd2;
   localparam logic [PHASE_W-1:0] PH_MEAS_LO   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_MEAS_HI   = 3'd4;

   // register byte addresses
   localparam logic [PADDR_W-1:0] REG_ENABLE    = 5'd0;
   localparam logic [PADDR_W-1:0] REG_TEST_MODE = 5'd4;
   localparam logic [PADDR_W-1:0] REG_P_GAIN    = 5'd8;
   localparam logic [PADDR_W-1:0] REG_D_GAIN    = 5'd12;
   localparam logic [PADDR_W-1:0] REG_TARGET    = 5'd16;
   localparam logic [PADDR_W-1:0] REG_EXP_LOW   = 5'd20;
   localparam logic [PADDR_W-1:0] REG_EXP_HIGH  = 5'd24;
   localparam logic [PADDR_W-1:0] REG_EXP_INIT  = 5'd28;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PD_MUL,
      ST_PD_ADD,
      ST_TEST,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_mean;
      logic pd_mul;
      logic pd_add;
      logic test_step;
      logic div_step;
      logic div_last;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic need_div;
   } status_type;

endpackage

// ----- rtl/auto_exposure_pd_with_latency_test_core.sv -----
// Top level of the auto-exposure PD controller with exposure latency test; uses aepd_pkg,
// aepd_ctrl and aepd_dpath.
// An accepted frame runs the PD multiply and add steps in PD mode, goes straight to
// the result when disabled, and in test mode runs a test step, then the 30-step divider
// when a measurement needs it. One frame at a time: a stalled result holds off the input.
// Reset (synchronous, active high) loads register defaults, exposure 10000, phase init.
`timescale 1ns / 1ps
module auto_exposure_pd_with_latency_test_core #(
   parameter int unsigned SETTLE_FRAMES  = aepd_pkg::SETTLE_FRAMES_DEF,
   parameter int unsigned TIMEOUT_FRAMES = aepd_pkg::TIMEOUT_FRAMES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // input stream
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [15:0]                  req_tdata,  // [14:0] frame_mean
   // result stream
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [79:0]                  rsp_tdata,  // [31:0] exposure_value, [44:32]
                                                    // latency_avg, [47:45] test_phase,
                                                    // [62:48] level_low, [77:63] level_high
   output logic [1:0]                   rsp_tuser,  // [0] exposure_write, [1] latency_valid
   // configuration
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [aepd_pkg::PADDR_W-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import aepd_pkg::*;

   // register file
   logic              en_ff, tm_ff;
   logic [GAIN_W-1:0] pg_ff, dg_ff;
   logic [MEAN_W-1:0] tgt_ff;
   logic [EXP_W-1:0]  elo_ff, ehi_ff, einit_ff;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= 1'b0;
         tm_ff    <= 1'b0;
         pg_ff    <= P_GAIN_RST;
         dg_ff    <= '0;
         tgt_ff   <= TARGET_RST;
         elo_ff   <= '0;
         ehi_ff   <= EXP_HIGH_RST;
         einit_ff <= EXP_INIT_RST;
      end else if (wr_en) begin
         case (csr_paddr)
            REG_ENABLE:    en_ff    <= csr_pwdata[0];
            REG_TEST_MODE: tm_ff    <= csr_pwdata[0];
            REG_P_GAIN:    pg_ff    <= csr_pwdata[GAIN_W-1:0];
            REG_D_GAIN:    dg_ff    <= csr_pwdata[GAIN_W-1:0];
            REG_TARGET:    tgt_ff   <= csr_pwdata[MEAN_W-1:0];
            REG_EXP_LOW:   elo_ff   <= csr_pwdata;
            REG_EXP_HIGH:  ehi_ff   <= csr_pwdata;
            REG_EXP_INIT:  einit_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         REG_ENABLE:    csr_prdata = {31'd0, en_ff};
         REG_TEST_MODE: csr_prdata = {31'd0, tm_ff};
         REG_P_GAIN:    csr_prdata = {16'd0, pg_ff};
         REG_D_GAIN:    csr_prdata = {16'd0, dg_ff};
         REG_TARGET:    csr_prdata = {17'd0, tgt_ff};
         REG_EXP_LOW:   csr_prdata = elo_ff;
         REG_EXP_HIGH:  csr_prdata = ehi_ff;
         REG_EXP_INIT:  csr_prdata = einit_ff;
         default:       csr_prdata = '0;
      endcase
   end

   // writing the start exposure also reloads the loop's exposure
   logic init_load;
   assign init_load = wr_en && (csr_paddr == REG_EXP_INIT);

   cmd_type    cmd;
   status_type status;

   aepd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .enable     (en_ff),
      .test_mode  (tm_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   logic              o_wr, o_lv;
   logic [EXP_W-1:0]  o_val;
   logic [AVG_W-1:0]  o_avg;
   logic [PHASE_W-1:0] o_ph;
   logic [MEAN_W-1:0] o_lo, o_hi;

   aepd_dpath #(
      .SETTLE_FRAMES  (SETTLE_FRAMES),
      .TIMEOUT_FRAMES (TIMEOUT_FRAMES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .frame_mean     (req_tdata[MEAN_W-1:0]),
      .p_gain         (pg_ff),
      .d_gain         (dg_ff),
      .target_mean    (tgt_ff),
      .exposure_low   (elo_ff),
      .exposure_high  (ehi_ff),
      .init_load      (init_load),
      .init_value     (csr_pwdata),
      .exposure_write (o_wr),
      .exposure_value (o_val),
      .latency_valid  (o_lv),
      .latency_avg    (o_avg),
      .test_phase     (o_ph),
      .level_low      (o_lo),
      .level_high     (o_hi)
   );

   assign rsp_tdata = {2'b00, o_hi, o_lo, o_ph, o_avg, o_val};
   assign rsp_tuser = {o_lv, o_wr};

endmodule

// ----- rtl/aepd_ctrl.sv -----
// Sequencer for the auto-exposure block: handshakes and datapath commands.
// Depends on aepd_pkg.
`timescale 1ns / 1ps
module aepd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                test_mode,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  aepd_pkg::status_type status,
   output aepd_pkg::cmd_type   cmd
);
   import aepd_pkg::*;

   state_type          state_ff, state_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;
   logic               ovalid_ff, ovalid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         dcnt_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         dcnt_ff   <= dcnt_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dcnt_in   = dcnt_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      cmd       = '0;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_mean = 1'b1;
               if (enable && !test_mode) state_in = ST_PD_MUL;
               else if (enable)          state_in = ST_TEST;
               else                      state_in = ST_DONE;
            end
         end
         ST_PD_MUL: begin
            cmd.pd_mul = 1'b1;
            state_in   = ST_PD_ADD;
         end
         ST_PD_ADD: begin
            cmd.pd_add = 1'b1;
            state_in   = ST_DONE;
         end
         ST_TEST: begin
            cmd.test_step = 1'b1;
            dcnt_in       = '0;
            state_in      = status.need_div ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               cmd.div_last = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!ovalid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               ovalid_in    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = ovalid_ff;

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && dcnt_ff == DCNT_W'(DIV_STEPS - 1)) |=> state_ff == ST_DONE)
      else $error("divider did not finish after its last step");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff != ST_IDLE)
      else $error("accepted transaction not processed");
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && ovalid_ff && !rsp_tready) |=> state_ff == ST_DONE)
      else $error("result overwritten while output stalled");
   a_test_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TEST |=> (state_ff == ST_DIV || state_ff == ST_DONE))
      else $error("bad exit from test step");

endmodule

// ----- rtl/aepd_dpath.sv -----
// Datapath: PD exposure loop, latency test state, restoring divider, result register.
// Depends on aepd_pkg; driven by aepd_ctrl commands.
`timescale 1ns / 1ps
module aepd_dpath #(
   parameter int unsigned SETTLE_FRAMES  = aepd_pkg::SETTLE_FRAMES_DEF,
   parameter int unsigned TIMEOUT_FRAMES = aepd_pkg::TIMEOUT_FRAMES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  aepd_pkg::cmd_type             cmd,
   output aepd_pkg::status_type          status,
   input  logic [aepd_pkg::MEAN_W-1:0]   frame_mean,
   input  logic [aepd_pkg::GAIN_W-1:0]   p_gain,
   input  logic [aepd_pkg::GAIN_W-1:0]   d_gain,
   input  logic [aepd_pkg::MEAN_W-1:0]   target_mean,
   input  logic [aepd_pkg::EXP_W-1:0]    exposure_low,
   input  logic [aepd_pkg::EXP_W-1:0]    exposure_high,
   input  logic                          init_load,
   input  logic [aepd_pkg::EXP_W-1:0]    init_value,
   output logic                          exposure_write,
   output logic [aepd_pkg::EXP_W-1:0]    exposure_value,
   output logic                          latency_valid,
   output logic [aepd_pkg::AVG_W-1:0]    latency_avg,
   output logic [aepd_pkg::PHASE_W-1:0]  test_phase,
   output logic [aepd_pkg::MEAN_W-1:0]   level_low,
   output logic [aepd_pkg::MEAN_W-1:0]   level_high
);
   import aepd_pkg::*;

   // loop state
   logic [EXP_W-1:0]   exp_ff;
   logic [MEAN_W-1:0]  prev_ff, mean_ff, low_ff, high_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic [1:0]         sr_ff;
   logic [FCNT_W-1:0]  fcnt_ff;
   logic [MCNT_W-1:0]  mcnt_ff;
   logic [AVG_W-1:0]   avg_ff;
   // working registers
   logic signed [2*GAIN_W-1:0] pc_ff, dc_ff;
   logic               wr_ff, lv_ff;
   logic [EXP_W-1:0]   val_ff;
   logic [NUM_W-1:0]   q_ff, q_in;
   logic [DEN_W-1:0]   den_ff, rem_ff, rem_in;
   // result register
   logic               o_wr_ff, o_lv_ff;
   logic [EXP_W-1:0]   o_val_ff;
   logic [AVG_W-1:0]   o_avg_ff;
   logic [PHASE_W-1:0] o_ph_ff;
   logic [MEAN_W-1:0]  o_lo_ff, o_hi_ff;

   // PD terms
   logic [MEAN_W-1:0]          prev_eff;
   logic signed [GAIN_W-1:0]   err_p, err_d;
   logic signed [2*GAIN_W:0]   corr_wide;
   logic signed [EXP_W-1:0]    corr;
   logic signed [EXP_W+1:0]    e_wide;
   logic [EXP_W-1:0]           e_sat;

   assign prev_eff = (prev_ff == '0) ? mean_ff : prev_ff;
   assign err_p = $signed({1'b0, target_mean}) - $signed({1'b0, mean_ff});
   assign err_d = $signed({1'b0, mean_ff}) - $signed({1'b0, prev_eff});
   assign corr_wide = (2*GAIN_W+1)'(pc_ff) + (2*GAIN_W+1)'(dc_ff);

   always_comb begin
      if (corr_wide[2*GAIN_W] != corr_wide[2*GAIN_W-1])
         corr = corr_wide[2*GAIN_W] ? {1'b1, {(EXP_W-1){1'b0}}} : {1'b0, {(EXP_W-1){1'b1}}};
      else
         corr = corr_wide[EXP_W-1:0];
      e_wide = $signed({2'b00, exp_ff}) + $signed({{2{corr[EXP_W-1]}}, corr});
      if (e_wide[EXP_W+1])    e_sat = '0;
      else if (e_wide[EXP_W]) e_sat = '1;
      else                    e_sat = e_wide[EXP_W-1:0];
   end

   // latency test step
   logic [CNT_W-1:0]   cnt;
   logic [PHASE_W-1:0] t_phase;
   logic [MEAN_W-1:0]  t_low, t_high, lvl, mean_diff;
   logic [1:0]         t_sr;
   logic               t_wr, t_lv, t_clr_mcnt, near;
   logic [EXP_W-1:0]   t_val;
   logic [MEAN_W+3:0]  diff_x10;
   logic [MEAN_W:0]    lvl_p10;

   assign lvl       = (phase_ff == PH_MEAS_LO) ? low_ff : high_ff;
   assign mean_diff = (mean_ff > lvl) ? mean_ff - lvl : lvl - mean_ff;
   assign diff_x10  = (MEAN_W+4)'(mean_diff) * (MEAN_W+4)'(10);
   assign lvl_p10   = (MEAN_W+1)'(lvl) + (MEAN_W+1)'(10);
   assign near      = diff_x10 < (MEAN_W+4)'(lvl_p10);
   assign status.need_div = near && (phase_ff == PH_MEAS_LO || phase_ff == PH_MEAS_HI);

   always_comb begin
      cnt        = CNT_W'(fcnt_ff);
      t_phase    = phase_ff;
      t_low      = low_ff;
      t_high     = high_ff;
      t_sr       = sr_ff;
      t_wr       = 1'b0;
      t_lv       = 1'b0;
      t_val      = '0;
      t_clr_mcnt = 1'b0;
      case (phase_ff)
         PH_SETTLE_LO: begin
            if (mean_ff < low_ff) begin
               t_low = mean_ff; cnt = '0;
            end else cnt = cnt + 1'b1;
            if (cnt == CNT_W'(SETTLE_FRAMES)) begin
               cnt = '0; t_high = mean_ff; t_wr = 1'b1;
               t_val = exposure_high; t_phase = PH_SETTLE_HI;
            end
         end
         PH_SETTLE_HI: begin
            if (mean_ff > high_ff) begin
               t_high = mean_ff; cnt = '0;
            end else cnt = cnt + 1'b1;
            if (cnt == CNT_W'(SETTLE_FRAMES)) begin
               cnt = '0; t_wr = 1'b1; t_val = exposure_low;
               t_sr = sr_ff + 1'b1;
               if (t_sr < 2'd2) begin
                  t_low = mean_ff; t_phase = PH_SETTLE_LO;
               end else t_phase = PH_MEAS_LO;
            end
         end
         PH_MEAS_LO, PH_MEAS_HI: begin
            if (near) begin
               t_lv = 1'b1; cnt = '0; t_wr = 1'b1;
               t_val   = (phase_ff == PH_MEAS_LO) ? exposure_high : exposure_low;
               t_phase = (phase_ff == PH_MEAS_LO) ? PH_MEAS_HI : PH_MEAS_LO;
            end else cnt = cnt + 1'b1;
         end
         default: begin
            t_sr = '0; cnt = '0; t_clr_mcnt = 1'b1;
            t_low = mean_ff; t_high = mean_ff;
            t_wr = 1'b1; t_val = exposure_high; t_phase = PH_SETTLE_HI;
         end
      endcase
      if (cnt > CNT_W'(TIMEOUT_FRAMES)) t_phase = PH_INIT;
   end

   // divider step
   logic [DEN_W:0] rem_try;
   always_comb begin
      rem_try = {rem_ff, q_ff[NUM_W-1]};
      if (rem_try >= {1'b0, den_ff}) begin
         rem_in = DEN_W'(rem_try - {1'b0, den_ff});
         q_in   = {q_ff[NUM_W-2:0], 1'b1};
      end else begin
         rem_in = rem_try[DEN_W-1:0];
         q_in   = {q_ff[NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff   <= EXP_INIT_RST;
         prev_ff  <= '0;
         phase_ff <= PH_INIT;
         sr_ff    <= '0;
         fcnt_ff  <= '0;
         mcnt_ff  <= '0;
         low_ff   <= '0;
         high_ff  <= '0;
         avg_ff   <= '0;
      end else begin
         if (init_load) begin
            exp_ff  <= init_value;
            prev_ff <= '0;
         end
         if (cmd.pd_mul) prev_ff <= mean_ff;
         if (cmd.pd_add) exp_ff  <= e_sat;
         if (cmd.test_step) begin
            phase_ff <= t_phase;
            low_ff   <= t_low;
            high_ff  <= t_high;
            sr_ff    <= t_sr;
            fcnt_ff  <= (cnt > CNT_W'(31)) ? '1 : cnt[FCNT_W-1:0];
            if (t_clr_mcnt)          mcnt_ff <= '0;
            else if (t_lv && mcnt_ff != '1) mcnt_ff <= mcnt_ff + 1'b1;
         end
         if (cmd.div_last) avg_ff <= q_in[AVG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_mean) begin
         mean_ff <= frame_mean;
         wr_ff   <= 1'b0;
         lv_ff   <= 1'b0;
         val_ff  <= '0;
      end
      if (cmd.pd_mul) begin
         pc_ff <= (2*GAIN_W)'(err_p) * (2*GAIN_W)'($signed(p_gain));
         dc_ff <= (2*GAIN_W)'(err_d) * (2*GAIN_W)'($signed(d_gain));
      end
      if (cmd.pd_add) begin
         wr_ff  <= 1'b1;
         val_ff <= e_sat;
      end
      if (cmd.test_step) begin
         wr_ff  <= t_wr;
         lv_ff  <= t_lv;
         val_ff <= t_val;
         q_ff   <= NUM_W'(mcnt_ff) * NUM_W'(avg_ff) + NUM_W'({fcnt_ff, 8'd0});
         den_ff <= DEN_W'(mcnt_ff) + 1'b1;
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
      if (cmd.out_load) begin
         o_wr_ff  <= wr_ff;
         o_lv_ff  <= lv_ff;
         o_val_ff <= val_ff;
         o_avg_ff <= avg_ff;
         o_ph_ff  <= phase_ff;
         o_lo_ff  <= low_ff;
         o_hi_ff  <= high_ff;
      end
   end

   assign exposure_write = o_wr_ff;
   assign exposure_value = o_val_ff;
   assign latency_valid  = o_lv_ff;
   assign latency_avg    = o_avg_ff;
   assign test_phase     = o_ph_ff;
   assign level_low      = o_lo_ff;
   assign level_high     = o_hi_ff;

endmodule
